// ===== sv/b64lw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64lw_pkg
// types, character codes and the alphabet lookup for the line-wrapped encoder
// ----------------------------------------------------------------------------
package b64lw_pkg;

    localparam int CHAR_W      = 7;
    localparam int GROUP_CHARS = 6;
    localparam int COUNT_W     = $clog2(GROUP_CHARS + 1);
    localparam int IDX_W       = $clog2(GROUP_CHARS);

    typedef logic [CHAR_W-1:0] char_t;

    localparam char_t CH_CR    = 7'd13;
    localparam char_t CH_LF    = 7'd10;
    localparam char_t CH_PAD   = 7'd61;
    localparam char_t CH_PLUS  = 7'd43;
    localparam char_t CH_SLASH = 7'd47;
    localparam char_t CH_UPPER = 7'd65;
    localparam char_t CH_LOWER = 7'd97;
    localparam char_t CH_DIGIT = 7'd48;

    // characters of one encoded group, first character at index 0
    typedef struct packed {
        logic [GROUP_CHARS-1:0][CHAR_W-1:0] chars;
        logic [COUNT_W-1:0]                 count;
        logic                               fin;
    } group_t;

    // standard alphabet lookup of one 6-bit value
    function automatic char_t b64_sym(input logic [5:0] v);
        char_t c;
        if (v < 6'd26)
        begin
            c = CH_UPPER + char_t'(v);
        end
        else if (v < 6'd52)
        begin
            c = CH_LOWER + char_t'(v - 6'd26);
        end
        else if (v < 6'd62)
        begin
            c = CH_DIGIT + char_t'(v - 6'd52);
        end
        else if (v == 6'd62)
        begin
            c = CH_PLUS;
        end
        else
        begin
            c = CH_SLASH;
        end
        return c;
    endfunction

endpackage

// ===== sv/base64_encoder_line_wrap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_encoder_line_wrap
// byte stream to base64 text with a cr lf pair after every full line
// ----------------------------------------------------------------------------
// usage
//   input channel s_*: one message byte per item, s_tlast on the last byte of
//   a message (messages hold at least one byte)
//   output channel m_*: one ascii character per item, m_tlast on the final
//   character of the encoded message
//   every third byte yields four alphabet characters, plus cr lf when the line
//   reaches LINE_CHARS; a short last group yields the padded tail, never cr lf
// timing
//   a byte that completes a group or ends the message is encoded in the cycle
//   it is accepted and registered into a group buffer, read out in turn
//   the output port moves one character per cycle while m_tready is high, so
//   with an always-ready receiver the output sets the pace of a full line (four
//   to six characters for each three bytes); every byte waits while both buffers are full
//   two group buffers hold encoded characters, so the input takes items while
//   the previous group is still draining and stalls only when both are full
// reset
//   rst_n clears the group phase, line count and both buffers; no item is
//   lost or repeated when the receiver holds m_tready low, data just waits
// ----------------------------------------------------------------------------
module base64_encoder_line_wrap
    import b64lw_pkg::*;
#(
    parameter int LINE_CHARS = 76
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // is_final
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic       m_tlast    // end_of_text
);

    localparam logic [CHAR_W-1:0] LINE_LIMIT = 7'(LINE_CHARS);

    // encoder state
    logic [7:0]        held_reg [2];
    logic [7:0]        held_next [2];
    logic [1:0]        phase_reg, phase_next;
    logic [CHAR_W-1:0] line_reg, line_next;

    // two group buffers used in order
    group_t            buf_reg [2];
    group_t            group_new;
    logic [1:0]        buf_valid_reg, buf_valid_next;
    logic              wr_sel_reg, wr_sel_next;
    logic              rd_sel_reg, rd_sel_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;

    logic              in_take, out_take, produce, rd_last;
    logic [1:0]        phase_eff;
    logic [CHAR_W-1:0] line_sum;
    group_t            cur;

    assign cur      = buf_reg[rd_sel_reg];
    assign s_tready = ~(buf_valid_reg[0] & buf_valid_reg[1]);
    assign m_tvalid = buf_valid_reg[rd_sel_reg];
    assign m_tdata  = {1'b0, cur.chars[rd_idx_reg]};
    assign rd_last  = (COUNT_W'(rd_idx_reg) == (cur.count - COUNT_W'(1)));
    assign m_tlast  = cur.fin & rd_last;

    assign in_take  = s_tvalid & s_tready;
    assign out_take = m_tvalid & m_tready;

    // encode one byte against the open group
    always_comb
    begin
        phase_eff    = (phase_reg == 2'd3) ? 2'd0 : phase_reg;
        produce      = (phase_eff == 2'd2) | s_tlast;
        line_sum     = line_reg + 7'd4;
        held_next    = held_reg;
        phase_next   = phase_reg;
        line_next    = line_reg;
        group_new    = '0;
        group_new.fin = s_tlast;

        if (phase_eff == 2'd2)
        begin
            // group complete: four characters, line wrap when full
            group_new.chars[0] = b64_sym(held_reg[0][7:2]);
            group_new.chars[1] = b64_sym({held_reg[0][1:0], held_reg[1][7:4]});
            group_new.chars[2] = b64_sym({held_reg[1][3:0], s_tdata[7:6]});
            group_new.chars[3] = b64_sym(s_tdata[5:0]);
            if (line_sum >= LINE_LIMIT)
            begin
                group_new.chars[4] = CH_CR;
                group_new.chars[5] = CH_LF;
                group_new.count    = COUNT_W'(6);
                line_next          = '0;
            end
            else
            begin
                group_new.count = COUNT_W'(4);
                line_next       = line_sum;
            end
            phase_next = 2'd0;
        end
        else if (s_tlast)
        begin
            group_new.count = COUNT_W'(4);
            if (phase_eff == 2'd0)
            begin
                // one leftover byte
                group_new.chars[0] = b64_sym(s_tdata[7:2]);
                group_new.chars[1] = b64_sym({s_tdata[1:0], 4'd0});
                group_new.chars[2] = CH_PAD;
                group_new.chars[3] = CH_PAD;
            end
            else
            begin
                // two leftover bytes
                group_new.chars[0] = b64_sym(held_reg[0][7:2]);
                group_new.chars[1] = b64_sym({held_reg[0][1:0], s_tdata[7:4]});
                group_new.chars[2] = b64_sym({s_tdata[3:0], 2'd0});
                group_new.chars[3] = CH_PAD;
            end
        end
        else
        begin
            held_next[phase_eff[0]] = s_tdata;
            phase_next              = phase_eff + 2'd1;
        end

        // end of message starts a fresh line and group
        if (s_tlast)
        begin
            phase_next = 2'd0;
            line_next  = '0;
        end
    end

    // buffer bookkeeping
    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        wr_sel_next    = wr_sel_reg;
        rd_sel_next    = rd_sel_reg;
        rd_idx_next    = rd_idx_reg;
        if (out_take)
        begin
            if (rd_last)
            begin
                buf_valid_next[rd_sel_reg] = 1'b0;
                rd_sel_next                = ~rd_sel_reg;
                rd_idx_next                = '0;
            end
            else
            begin
                rd_idx_next = rd_idx_reg + IDX_W'(1);
            end
        end
        if (in_take && produce)
        begin
            buf_valid_next[wr_sel_reg] = 1'b1;
            wr_sel_next                = ~wr_sel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg[0]   <= '0;
            held_reg[1]   <= '0;
            phase_reg     <= '0;
            line_reg      <= '0;
            buf_valid_reg <= '0;
            wr_sel_reg    <= 1'b0;
            rd_sel_reg    <= 1'b0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            if (in_take)
            begin
                held_reg  <= held_next;
                phase_reg <= phase_next;
                line_reg  <= line_next;
            end
            buf_valid_reg <= buf_valid_next;
            wr_sel_reg    <= wr_sel_next;
            rd_sel_reg    <= rd_sel_next;
            rd_idx_reg    <= rd_idx_next;
        end
    end

    // group buffer payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take && produce)
        begin
            buf_reg[wr_sel_reg] <= group_new;
        end
    end

`ifndef SYNTHESIS
    // a new group never lands on a buffer still draining
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && produce) |-> !buf_valid_reg[wr_sel_reg])
        else $error("group written over a pending buffer");

    // pending groups hold four or six characters
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (cur.count == COUNT_W'(4) || cur.count == COUNT_W'(6)))
        else $error("bad group character count");

    // read index stays inside the group
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (COUNT_W'(rd_idx_reg) < cur.count))
        else $error("read index past group end");

    // the character after a completed group comes from the other buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && rd_last) |=> (rd_idx_reg == '0 && rd_sel_reg != $past(rd_sel_reg)))
        else $error("buffer switch missed");
`endif

endmodule
